// ===== src/lfsa_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and bit-scan helpers for the lowest free slot allocator.
// No dependencies; every other file of the block but lfsa_ram.sv uses this package.
package lfsa_pkg;

  localparam int unsigned SLOT_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(SLOT_COUNT);
  localparam int unsigned LEN_W      = IDX_W + 1;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned BIT_W      = $clog2(WORD_W);
  localparam int unsigned WORDS      = SLOT_COUNT / WORD_W;
  localparam int unsigned WADDR_W    = $clog2(WORDS);

  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE         = 2'd0,
    ST_ALREADY_FREE = 2'd1,
    ST_FULL         = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef struct packed {
    logic [IDX_W-1:0] granted_slot;
    status_e          status;
    logic [LEN_W-1:0] used_length;
    logic [LEN_W-1:0] free_holes;
  } rsp_t;

  typedef struct packed {
    logic               we;
    logic [WADDR_W-1:0] waddr;
    logic [WORD_W-1:0]  wdata;
    logic               re;
    logic [WADDR_W-1:0] raddr;
  } mem_req_t;

  // Index of the lowest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Index of the highest set bit; zero when no bit is set.
  function automatic logic [BIT_W-1:0] highest_bit(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] r;
    r = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (v[i]) r = BIT_W'(i);
    end
    return r;
  endfunction

  // Lowest word whose summary bit is set.
  function automatic logic [WADDR_W-1:0] lowest_word(input logic [WORDS-1:0] v);
    logic [WADDR_W-1:0] r;
    r = '0;
    for (int i = WORDS - 1; i >= 0; i--) begin
      if (v[i]) r = WADDR_W'(i);
    end
    return r;
  endfunction

endpackage

// ===== src/lfsa_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the allocator.
// Depends on lfsa_pkg for the field widths.
interface lfsa_req_if;
  logic                      valid;
  logic                      ready;
  logic                      func;
  logic [lfsa_pkg::IDX_W-1:0] slot_to_free;

  modport source (output valid, output func, output slot_to_free, input ready);
  modport sink   (input valid, input func, input slot_to_free, output ready);
endinterface

interface lfsa_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [lfsa_pkg::IDX_W-1:0] granted_slot;
  logic [1:0]                status;
  logic [lfsa_pkg::LEN_W-1:0] used_length;
  logic [lfsa_pkg::LEN_W-1:0] free_holes;

  modport source (output valid, output granted_slot, output status, output used_length,
                  output free_holes, input ready);
  modport sink   (input valid, input granted_slot, input status, input used_length,
                  input free_holes, output ready);
endinterface

// ===== src/lfsa_ram.sv =====
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module lfsa_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== src/lfsa_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the allocator: word summary, length and hole counters, and the
// read-modify-write of the hole bitmap. Depends on lfsa_pkg.
module lfsa_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  output logic                     req_ready_o,
  input  logic                     func_i,
  input  logic [lfsa_pkg::IDX_W-1:0] slot_i,
  output logic                     rsp_valid_o,
  input  logic                     rsp_ready_i,
  output lfsa_pkg::rsp_t           rsp_o,
  output lfsa_pkg::mem_req_t       mem_o,
  input  logic [lfsa_pkg::WORD_W-1:0] rdata_i
);
  import lfsa_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_TRIM = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [LEN_W-1:0]   len_q, len_d;
  logic [LEN_W-1:0]   cnt_q, cnt_d;
  logic [WORDS-1:0]   sum_q, sum_d;
  logic [WADDR_W-1:0] w_q, w_d;
  logic               func_q, func_d;
  logic [IDX_W-1:0]   idx_q, idx_d;
  logic [IDX_W-1:0]   grant_q, grant_d;
  status_e            stat_q, stat_d;

  logic [WORD_W-1:0]  word;
  logic [BIT_W-1:0]   bpos;
  logic [IDX_W-1:0]   prev_idx;
  logic [LEN_W-1:0]   last;
  logic [BIT_W-1:0]   tpos;
  logic [WORD_W-1:0]  tmask;
  logic [WORD_W-1:0]  zeros;
  logic [BIT_W-1:0]   hz;

  // A word whose summary bit is clear holds no holes, whatever the RAM says.
  assign word     = sum_q[w_q] ? rdata_i : '0;
  assign bpos     = lowest_bit(word);
  assign prev_idx = idx_q - IDX_W'(1);
  assign last     = len_q - LEN_W'(1);
  assign tpos     = last[BIT_W-1:0];
  assign tmask    = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - tpos);
  assign zeros    = ~word & tmask;
  assign hz       = highest_bit(zeros);

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_EMIT);
  assign rsp_o = '{granted_slot: grant_q, status: stat_q, used_length: len_q,
                   free_holes: cnt_q};

  always_comb begin
    state_d = state_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    sum_d   = sum_q;
    w_d     = w_q;
    func_d  = func_q;
    idx_d   = idx_q;
    grant_d = grant_q;
    stat_d  = stat_q;
    mem_o   = '{we: 1'b0, waddr: w_q, wdata: '0, re: 1'b0, raddr: w_q};

    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          func_d  = func_i;
          idx_d   = slot_i;
          grant_d = '0;
          stat_d  = ST_DONE;
          if (func_i == FUNC_ALLOC) begin
            if (cnt_q != '0) begin
              w_d         = lowest_word(sum_q);
              mem_o.re    = 1'b1;
              mem_o.raddr = lowest_word(sum_q);
              state_d     = S_LOOK;
            end else if (len_q != LEN_W'(SLOT_COUNT)) begin
              grant_d = len_q[IDX_W-1:0];
              len_d   = len_q + LEN_W'(1);
              state_d = S_EMIT;
            end else begin
              stat_d  = ST_FULL;
              state_d = S_EMIT;
            end
          end else if ({1'b0, slot_i} >= len_q) begin
            stat_d  = ST_RANGE;
            state_d = S_EMIT;
          end else begin
            w_d         = slot_i[IDX_W-1:BIT_W];
            mem_o.re    = 1'b1;
            mem_o.raddr = slot_i[IDX_W-1:BIT_W];
            state_d     = S_LOOK;
          end
        end
      end

      S_LOOK: begin
        if (func_q == FUNC_ALLOC) begin
          grant_d     = {w_q, bpos};
          mem_o.we    = 1'b1;
          mem_o.wdata = word & ~(WORD_W'(1) << bpos);
          sum_d[w_q]  = |mem_o.wdata;
          cnt_d       = cnt_q - LEN_W'(1);
          state_d     = S_EMIT;
        end else if (word[idx_q[BIT_W-1:0]]) begin
          stat_d  = ST_ALREADY_FREE;
          state_d = S_EMIT;
        end else if ({1'b0, idx_q} + LEN_W'(1) == len_q) begin
          // Releasing the last slot: shrink, then drop holes left at the tail.
          len_d = {1'b0, idx_q};
          if (idx_q == '0) begin
            state_d = S_EMIT;
          end else begin
            w_d         = prev_idx[IDX_W-1:BIT_W];
            mem_o.re    = 1'b1;
            mem_o.raddr = prev_idx[IDX_W-1:BIT_W];
            state_d     = S_TRIM;
          end
        end else begin
          mem_o.we    = 1'b1;
          mem_o.wdata = word | (WORD_W'(1) << idx_q[BIT_W-1:0]);
          sum_d[w_q]  = 1'b1;
          cnt_d       = cnt_q + LEN_W'(1);
          state_d     = S_EMIT;
        end
      end

      S_TRIM: begin
        // The new tail slot is bit tpos of word w_q; drop the run of holes ending there.
        mem_o.we = 1'b1;
        if (zeros == '0) begin
          mem_o.wdata = word & ~tmask;
          sum_d[w_q]  = |mem_o.wdata;
          cnt_d       = cnt_q - (LEN_W'(tpos) + LEN_W'(1));
          len_d       = {1'b0, w_q, {BIT_W{1'b0}}};
          if (w_q == '0) begin
            state_d = S_EMIT;
          end else begin
            w_d         = w_q - WADDR_W'(1);
            mem_o.re    = 1'b1;
            mem_o.raddr = w_q - WADDR_W'(1);
          end
        end else begin
          mem_o.wdata = word & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hz));
          sum_d[w_q]  = |mem_o.wdata;
          cnt_d       = cnt_q - LEN_W'(tpos - hz);
          len_d       = {1'b0, w_q, hz} + LEN_W'(1);
          state_d     = S_EMIT;
        end
      end

      S_EMIT: begin
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= '0;
      cnt_q   <= '0;
      sum_q   <= '0;
    end else begin
      state_q <= state_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
      sum_q   <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    w_q     <= w_d;
    func_q  <= func_d;
    idx_q   <= idx_d;
    grant_q <= grant_d;
    stat_q  <= stat_d;
  end

endmodule

// ===== src/lowest_free_slot_allocator.sv =====
`timescale 1ns / 1ps
// From request transfer to the output register: an append or a request rejected from the
// counters goes straight to the result; else the bitmap word is read, then updated or the
// request rejected; freeing the last slot trims tail holes in up to SLOT_COUNT/32 words.
// A new request is taken the cycle after the result enters the output register.
// The bitmap lives in a 32-bit-wide RAM; one bitmap word per cycle sets the trim rate.
// Reset clears length, hole count and the per-word summary; the RAM needs no clearing pass.
module lowest_free_slot_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfsa_req_if.sink    req_i,
  lfsa_rsp_if.source  rsp_o
);
  import lfsa_pkg::*;

  logic     ctrl_rsp_valid;
  logic     ctrl_rsp_ready;
  rsp_t     ctrl_rsp;
  mem_req_t mem_req;
  logic [WORD_W-1:0] mem_rdata;

  logic out_valid_q;
  rsp_t out_q;

  lfsa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .func_i      (req_i.func),
    .slot_i      (req_i.slot_to_free),
    .rsp_valid_o (ctrl_rsp_valid),
    .rsp_ready_i (ctrl_rsp_ready),
    .rsp_o       (ctrl_rsp),
    .mem_o       (mem_req),
    .rdata_i     (mem_rdata)
  );

  lfsa_ram #(
    .DEPTH (WORDS),
    .WIDTH (WORD_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.wdata),
    .re_i    (mem_req.re),
    .raddr_i (mem_req.raddr),
    .rdata_o (mem_rdata)
  );

  // The output register frees the sequencer while a result waits for its transfer.
  assign ctrl_rsp_ready = !out_valid_q || rsp_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_rsp_ready) begin
      out_valid_q <= ctrl_rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_rsp_ready && ctrl_rsp_valid) begin
      out_q <= ctrl_rsp;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.granted_slot = out_q.granted_slot;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.used_length  = out_q.used_length;
  assign rsp_o.free_holes   = out_q.free_holes;

endmodule

// ===== src/lfsa_chk.sv =====
`timescale 1ns / 1ps
// Port-level checker for the allocator, attached to the top level by bind.
// Depends on lfsa_pkg and on the top level's port names.
module lfsa_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       rsp_valid_i,
  input logic                       rsp_ready_i,
  input logic [lfsa_pkg::IDX_W-1:0] granted_slot_i,
  input logic [1:0]                 status_i,
  input logic [lfsa_pkg::LEN_W-1:0] used_length_i,
  input logic [lfsa_pkg::LEN_W-1:0] free_holes_i
);
  import lfsa_pkg::*;

  // A waiting result must not vanish before its transfer.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("result dropped before transfer");

  // A rejected request reports no slot.
  a_grant_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i != ST_DONE) |-> granted_slot_i == '0)
    else $error("nonzero slot on a rejected request");

  // Full means every slot is live.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (status_i == ST_FULL) |->
      (used_length_i == LEN_W'(SLOT_COUNT)) && (free_holes_i == '0))
    else $error("full reported with room left");

  // Holes lie strictly below the length and the length never exceeds the slot count.
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (used_length_i <= LEN_W'(SLOT_COUNT)) && (free_holes_i <= used_length_i)
      && ((free_holes_i == '0) || (free_holes_i != used_length_i)))
    else $error("length or hole count out of bounds");

endmodule

bind lowest_free_slot_allocator lfsa_chk u_lfsa_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .granted_slot_i (rsp_o.granted_slot),
  .status_i       (rsp_o.status),
  .used_length_i  (rsp_o.used_length),
  .free_holes_i   (rsp_o.free_holes)
);

// ===== tb/lfsa_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the lowest free slot allocator: keeps its own slot map, predicts the
// result of every request transfer and compares each result transfer field by field.
// Depends on lfsa_pkg and on the channel interfaces of lfsa_if.sv.
module lfsa_checker
  import lfsa_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  lfsa_req_if              req_i,
  lfsa_rsp_if              rsp_i,
  output int unsigned      fail_count_o,
  output int unsigned      pending_o,
  output logic [LEN_W-1:0] live_len_o
);

  bit          hole_map [SLOT_COUNT];
  int unsigned live_len;
  int unsigned hole_cnt;
  rsp_t        awaited_results [$];

  // Updates the slot map for one request and returns the result it must produce.
  function automatic rsp_t apply_request(input logic func, input logic [IDX_W-1:0] slot);
    rsp_t        res;
    int unsigned h;
    res = '0;
    res.status = ST_DONE;
    if (func == FUNC_ALLOC) begin
      h = 0;
      if (hole_cnt != 0) begin
        while (h < live_len && !hole_map[h]) h++;
      end else begin
        h = live_len;
      end
      if (h < live_len) begin
        hole_map[h] = 1'b0;
        hole_cnt--;
        res.granted_slot = IDX_W'(h);
      end else begin
        hole_cnt = 0;
        if (live_len < SLOT_COUNT) begin
          res.granted_slot = IDX_W'(live_len);
          live_len++;
        end else begin
          res.status = ST_FULL;
        end
      end
    end else begin
      if (slot >= live_len) begin
        res.status = ST_RANGE;
      end else if (hole_map[slot]) begin
        res.status = ST_ALREADY_FREE;
      end else if (slot + 1 == live_len) begin
        // Releasing the top slot also drops every hole that ends up at the tail.
        live_len--;
        while (live_len > 0 && hole_map[live_len-1]) begin
          hole_map[live_len-1] = 1'b0;
          if (hole_cnt > 0) hole_cnt--;
          live_len--;
        end
      end else begin
        hole_map[slot] = 1'b1;
        hole_cnt++;
      end
    end
    res.used_length = LEN_W'(live_len);
    res.free_holes  = LEN_W'(hole_cnt);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      foreach (hole_map[i]) hole_map[i] = 1'b0;
      live_len = 0;
      hole_cnt = 0;
      awaited_results.delete();
      fail_count_o = 0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        awaited_results.insert(awaited_results.size(),
                               apply_request(req_i.func, req_i.slot_to_free));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        if (awaited_results.size() == 0) begin
          if (fail_count_o < 10) begin
            $display("Unexpected result transfer: slot %0d status %0d length %0d holes %0d",
                     rsp_i.granted_slot, rsp_i.status, rsp_i.used_length, rsp_i.free_holes);
          end
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp_i.granted_slot !== want.granted_slot || rsp_i.status !== want.status ||
              rsp_i.used_length !== want.used_length || rsp_i.free_holes !== want.free_holes)
          begin
            if (fail_count_o < 10) begin
              $display("Mismatch: expected slot %0d status %0d length %0d holes %0d",
                       want.granted_slot, want.status, want.used_length, want.free_holes);
              $display("          actual   slot %0d status %0d length %0d holes %0d",
                       rsp_i.granted_slot, rsp_i.status, rsp_i.used_length, rsp_i.free_holes);
            end
            fail_count_o++;
          end
        end
      end
    end
    pending_o  = awaited_results.size();
    live_len_o = LEN_W'(live_len);
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// Top of the allocator testbench: clock, reset, request stimulus and result stalls.
// Depends on lfsa_pkg, lfsa_if.sv, the allocator RTL and tb/lfsa_checker.sv.
module testbench;
  import lfsa_pkg::*;

  typedef enum int {MIX_GROW, MIX_SCATTER, MIX_TRIM, MIX_NOISE} mix_e;

  localparam int unsigned QUIET_LIMIT = 4000;

  logic             clk_i;
  logic             rst_ni;
  bit               calm = 1'b0;
  int unsigned      fail_count;
  int unsigned      pending;
  logic [LEN_W-1:0] live_len;
  int unsigned      quiet_cycles = 0;

  lfsa_req_if req_if ();
  lfsa_rsp_if rsp_if ();

  lowest_free_slot_allocator uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  lfsa_checker result_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_if),
    .rsp_i        (rsp_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .live_len_o   (live_len)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  always @(negedge clk_i) begin
    rsp_if.ready <= calm || ($urandom_range(99) >= 17);
  end

  // Ends the run when neither channel has completed a transfer for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one request after a random gap and returns at the edge of its transfer.
  task automatic send_request(input logic func, input logic [IDX_W-1:0] slot);
    while (!calm && $urandom_range(99) < 17) begin
      @(negedge clk_i);
      req_if.valid        <= 1'b0;
      req_if.func         <= 1'($urandom);
      req_if.slot_to_free <= IDX_W'($urandom);
    end
    @(negedge clk_i);
    req_if.valid        <= 1'b1;
    req_if.func         <= func;
    req_if.slot_to_free <= slot;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  initial begin
    mix_e             mode;
    logic             is_free;
    logic [IDX_W-1:0] pick;
    int unsigned      len;

    rst_ni              = 1'b0;
    req_if.valid        = 1'b0;
    req_if.func         = FUNC_ALLOC;
    req_if.slot_to_free = '0;
    rsp_if.ready        = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // Small directed sequence: holes, reuse, already free, out of range, tail trimming.
    repeat (4) send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, 10'd1);
    send_request(FUNC_FREE, 10'd1);
    send_request(FUNC_FREE, 10'd4);
    send_request(FUNC_FREE, 10'd1023);
    send_request(FUNC_ALLOC, 10'd1023);
    send_request(FUNC_FREE, 10'd2);
    send_request(FUNC_FREE, 10'd1);
    send_request(FUNC_ALLOC, '0);
    send_request(FUNC_FREE, 10'd1);
    send_request(FUNC_FREE, 10'd3);
    send_request(FUNC_FREE, 10'd0);
    send_request(FUNC_FREE, 10'd0);
    send_request(FUNC_ALLOC, '0);
    drain_results();

    // Random blocks, each with its own mix of allocates and frees.
    for (int b = 0; b < 19; b++) begin
      calm = (b >= 8 && b < 11);
      if ($urandom_range(4) == 0) drain_results();
      mode = mix_e'($urandom_range(3));
      for (int n = 0; n < 40; n++) begin
        len = live_len;
        unique case (mode)
          MIX_GROW:    is_free = ($urandom_range(99) < 15);
          MIX_SCATTER: is_free = ($urandom_range(99) < 80);
          MIX_TRIM:    is_free = ($urandom_range(99) < 90);
          default:     is_free = 1'($urandom);
        endcase
        if (len == 0 || mode == MIX_NOISE || $urandom_range(99) < 5) begin
          pick = IDX_W'($urandom);
        end else if (mode == MIX_TRIM && $urandom_range(99) < 70) begin
          pick = IDX_W'(len - 1);
        end else begin
          pick = IDX_W'($urandom_range(len - 1, 0));
        end
        send_request(is_free ? FUNC_FREE : FUNC_ALLOC, pick);
      end
    end
    calm = 1'b0;

    drain_results();
    repeat (64) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
